/* design/ddwp_pkg.sv */
// Shared types and constants for the decimal digit to word packer.
package ddwp_pkg;

    localparam int WORD_W  = 30;
    localparam int DIGIT_W = 4;
    localparam int COUNT_W = 7;
    localparam int SCALE_W = 5;
    localparam int SLOT_W  = 4;

    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

    // Powers of ten used to left-align a short fraction tail.
    localparam logic [WORD_W-1:0] POW10 [10] = '{
        30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
        30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
    };

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [COUNT_W-1:0] digit_count;
        logic [SCALE_W-1:0] scale_in;
        logic               negative_in;
        logic               first_digit;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic               word_valid;
        logic [SLOT_W-1:0]  word_slot;
        logic [COUNT_W-1:0] int_digits;
        logic [SCALE_W-1:0] frac_digits;
        logic               negative_out;
        logic               number_done;
    } t_result;

endpackage

/* design/ddwp_in_reg.sv */
// Input register stage: captures one digit item per cycle unless stalled.
module ddwp_in_reg
    import ddwp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_stall,
    input  logic  i_advance,
    output logic  o_item_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Hold while the item here cannot move on.
    assign o_stall = r_valid && !i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

/* design/ddwp_core.sv */
// Packing logic: group accumulator, digit counters and word emission.
module ddwp_core
    import ddwp_pkg::*;
#(
    parameter int DIGITS_PER_GROUP = 9,
    parameter int MAX_SLOTS        = 9,
    parameter int MAX_DIGITS       = 65
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_has_result,
    output t_result o_result
);

    localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int TAB_DEPTH  = 2 ** COUNT_W;

    typedef logic [3:0] t_mod_tab [TAB_DEPTH];

    function automatic t_mod_tab build_mod_tab();
        t_mod_tab tab;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            tab[i] = 4'(i % DIGITS_PER_GROUP);
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = build_mod_tab();

    logic [WORD_W-1:0]     r_acc,   n_acc;
    logic [COUNT_W-1:0]    r_seen,  n_seen;
    logic [SLOT_CNT_W-1:0] r_slot,  n_slot;
    logic [COUNT_W-1:0]    r_tally, n_tally;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [SCALE_W-1:0]    r_scale, n_scale;
    logic                  r_sign,  n_sign;

    logic [DIGIT_W-1:0]    d;
    logic [COUNT_W-1:0]    cnt_sat;
    logic [SCALE_W-1:0]    sc_sat;
    logic [WORD_W-1:0]     acc_b;
    logic [COUNT_W-1:0]    seen_b;
    logic [SLOT_CNT_W-1:0] slot_b;
    logic [COUNT_W-1:0]    tally_b;
    logic                  zero_dec;
    logic                  active;
    logic [WORD_W-1:0]     acc_new;
    logic [COUNT_W-1:0]    p;
    logic [COUNT_W-1:0]    int_n;
    logic [COUNT_W-1:0]    frac_pos;
    logic [3:0]            tail;
    logic [3:0]            k;
    logic [3:0]            k_up;
    logic [2*WORD_W-1:0]   prod_hi;
    logic [WORD_W+DIGIT_W-1:0] prod_lo;
    logic [WORD_W-1:0]     w_tail;
    logic [WORD_W-1:0]     w;
    logic                  done;
    logic                  is_int;
    logic                  closes;
    logic                  drop;
    logic                  store;

    always_comb begin
        d = (i_item.digit > MAX_DIGIT) ? MAX_DIGIT : i_item.digit;

        cnt_sat = (i_item.digit_count > COUNT_W'(MAX_DIGITS)) ?
                  COUNT_W'(MAX_DIGITS) : i_item.digit_count;
        sc_sat  = ({2'b00, i_item.scale_in} > cnt_sat) ?
                  cnt_sat[SCALE_W-1:0] : i_item.scale_in;

        // A first item restarts the number before its digit is used.
        if (i_item.first_digit) begin
            n_count = cnt_sat;
            n_scale = sc_sat;
            n_sign  = i_item.negative_in;
            acc_b   = '0;
            seen_b  = '0;
            slot_b  = '0;
            tally_b = cnt_sat - {2'b00, sc_sat};
        end else begin
            n_count = r_count;
            n_scale = r_scale;
            n_sign  = r_sign;
            acc_b   = r_acc;
            seen_b  = r_seen;
            slot_b  = r_slot;
            tally_b = r_tally;
        end

        zero_dec = i_item.first_digit && (cnt_sat == '0);
        active   = !zero_dec && (seen_b < n_count);

        acc_new = WORD_W'(({4'b0000, acc_b} << 3) + ({4'b0000, acc_b} << 1)
                          + (WORD_W + 4)'(d));
        p        = seen_b + 7'd1;
        int_n    = n_count - {2'b00, n_scale};
        done     = (p == n_count);
        is_int   = (p <= int_n);
        frac_pos = p - int_n;
        tail     = MOD_TAB[frac_pos];

        // Short tail: acc*10^(k+1) + d*10^k, with k the missing digits.
        k       = 4'(DIGITS_PER_GROUP) - tail;
        k_up    = (tail == 4'd0) ? 4'd0 : k + 4'd1;
        prod_hi = (2*WORD_W)'(acc_b) * (2*WORD_W)'(POW10[k_up]);
        prod_lo = (WORD_W+DIGIT_W)'(d) * (WORD_W+DIGIT_W)'(POW10[k]);
        w_tail  = WORD_W'(prod_hi) + WORD_W'(prod_lo);

        if (is_int) begin
            closes = (MOD_TAB[int_n - p] == 4'd0);
            w      = acc_new;
        end else if (tail == 4'd0) begin
            closes = 1'b1;
            w      = acc_new;
        end else begin
            closes = done;
            w      = w_tail;
        end

        drop  = is_int && (w == '0) && (slot_b == '0);
        store = !drop && (slot_b < SLOT_CNT_W'(MAX_SLOTS));

        n_seen  = active ? p : seen_b;
        n_acc   = (active && closes) ? '0 : (active ? acc_new : acc_b);
        n_tally = (active && closes && drop) ? (int_n - p) : tally_b;
        n_slot  = (active && closes && store) ? slot_b + SLOT_CNT_W'(1) : slot_b;

        o_has_result = zero_dec || (active && closes);

        o_result.word         = (!zero_dec && store) ? w : '0;
        o_result.word_valid   = !zero_dec && store;
        o_result.word_slot    = (!zero_dec && store) ? SLOT_W'(slot_b) : '0;
        o_result.int_digits   = n_tally;
        o_result.frac_digits  = n_scale;
        o_result.negative_out = n_sign;
        o_result.number_done  = zero_dec || done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_seen  <= '0;
            r_slot  <= '0;
            r_tally <= '0;
            r_count <= '0;
            r_scale <= '0;
            r_sign  <= 1'b0;
        end else if (i_fire) begin
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_slot  <= n_slot;
            r_tally <= n_tally;
            r_count <= n_count;
            r_scale <= n_scale;
            r_sign  <= n_sign;
        end
    end

endmodule

/* design/ddwp_out_reg.sv */
// Result register: holds one word result until the receiver takes it.
module ddwp_out_reg
    import ddwp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  logic    i_has_result,
    input  t_result i_result,
    output logic    o_advance,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire && i_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_fire && i_has_result) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/decimal_digits_to_word_packer.sv */
// Top level of the decimal digit to base-1e9 word packer.
//
// Input channel (i_valid / o_stall): one decimal digit per word, most
// significant first, with the number's digit count, scale and sign; the
// first digit of each number is flagged by i_first_digit.
// Output channel (o_valid / i_stall): one result per closed digit group,
// or one result for a zero-digit number. Most digits give no result.
// Throughput: one digit per cycle while the receiver does not stall, set by the
// group accumulator, which does its multiply-by-ten and add combinationally.
// A digit is first captured in the input register; its result is then formed
// by the core and loaded into the result register, where the receiver takes it.
// When the receiver stalls on a held result, the result register holds; the
// input register takes one more digit if empty, then o_stall rises until the result moves.
// Reset empties both registers and clears all counters; the block accepts
// digits as soon as reset is released. Digits before any first digit, or past
// the declared count, are dropped without a result.
module decimal_digits_to_word_packer
    import ddwp_pkg::*;
#(
    parameter int DIGITS_PER_GROUP = 9,
    parameter int MAX_SLOTS        = 9,
    parameter int MAX_DIGITS       = 65
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [DIGIT_W-1:0] i_digit,
    input  logic [COUNT_W-1:0] i_digit_count,
    input  logic [SCALE_W-1:0] i_scale_in,
    input  logic               i_negative_in,
    input  logic               i_first_digit,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WORD_W-1:0]  o_word,
    output logic               o_word_valid,
    output logic [SLOT_W-1:0]  o_word_slot,
    output logic [COUNT_W-1:0] o_int_digits,
    output logic [SCALE_W-1:0] o_frac_digits,
    output logic               o_negative_out,
    output logic               o_number_done
);

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    logic    fire;
    logic    has_result;
    t_result core_result;
    t_result out_result;

    always_comb begin
        in_item.digit       = i_digit;
        in_item.digit_count = i_digit_count;
        in_item.scale_in    = i_scale_in;
        in_item.negative_in = i_negative_in;
        in_item.first_digit = i_first_digit;
    end

    assign fire = stage_valid && advance;

    ddwp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (in_item),
        .o_stall      (o_stall),
        .i_advance    (advance),
        .o_item_valid (stage_valid),
        .o_item       (stage_item)
    );

    ddwp_core #(
        .DIGITS_PER_GROUP (DIGITS_PER_GROUP),
        .MAX_SLOTS        (MAX_SLOTS),
        .MAX_DIGITS       (MAX_DIGITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (stage_item),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    ddwp_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_has_result (has_result),
        .i_result     (core_result),
        .o_advance    (advance),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (out_result)
    );

    assign o_word         = out_result.word;
    assign o_word_valid   = out_result.word_valid;
    assign o_word_slot    = out_result.word_slot;
    assign o_int_digits   = out_result.int_digits;
    assign o_frac_digits  = out_result.frac_digits;
    assign o_negative_out = out_result.negative_out;
    assign o_number_done  = out_result.number_done;

endmodule

/* design/ddwp_checker.sv */
// Port-level checks for the word packer, bound to the top level.
module ddwp_checker
    import ddwp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [WORD_W-1:0]  o_word,
    input logic               o_word_valid,
    input logic [SLOT_W-1:0]  o_word_slot
);

    // An unstored word result carries neither value nor slot.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word_valid |-> o_word == '0 && o_word_slot == '0)
        else $error("unstored word result carries data");

    // Packed words stay below one billion.
    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_word <= 30'd999999999)
        else $error("packed word out of range");

    // Both registers come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not empty after reset");

    // The input side only stalls while a result is held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with result path free");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("stalled result changed");

endmodule

bind decimal_digits_to_word_packer ddwp_checker u_ddwp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_word       (o_word),
    .o_word_valid (o_word_valid),
    .o_word_slot  (o_word_slot)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the decimal digit to base-1e9 word packer.
import ddwp_pkg::*;

class digit_pack_scoreboard;
    localparam int unsigned GROUP_DIGITS = 9;
    localparam int unsigned SLOT_LIMIT   = 9;
    localparam int unsigned DIGIT_LIMIT  = 65;

    // packing state, mirrors the block after reset
    int unsigned group_value   = 0;
    int unsigned digits_taken  = 0;
    int unsigned slot_next     = 0;
    int unsigned int_tally     = 0;
    int unsigned count_held    = 0;
    int unsigned scale_held    = 0;
    bit          sign_held     = 1'b0;

    t_result     pending_words[$];
    int unsigned fail_count    = 0;
    int unsigned result_index  = 0;

    function void push_word(int unsigned w, bit stored, int unsigned slot, bit last);
        t_result r;
        r.word         = w[WORD_W-1:0];
        r.word_valid   = stored;
        r.word_slot    = slot[SLOT_W-1:0];
        r.int_digits   = int_tally[COUNT_W-1:0];
        r.frac_digits  = scale_held[SCALE_W-1:0];
        r.negative_out = sign_held;
        r.number_done  = last;
        pending_words.push_back(r);
    endfunction

    // Accepted input word: advance the packing state, queue any result it closes.
    function void note_digit(t_item it);
        int unsigned d, cnt, sc, pos, int_n, tail, w;
        bit closes, is_int, last;
        d = (it.digit > MAX_DIGIT) ? MAX_DIGIT : it.digit;
        closes = 1'b0;
        if (it.first_digit) begin
            cnt = it.digit_count;
            if (cnt > DIGIT_LIMIT) cnt = DIGIT_LIMIT;
            sc = it.scale_in;
            if (sc > cnt) sc = cnt;
            count_held   = cnt;
            scale_held   = sc;
            sign_held    = it.negative_in;
            digits_taken = 0;
            slot_next    = 0;
            group_value  = 0;
            int_tally    = cnt - sc;
            if (cnt == 0) begin
                push_word(0, 1'b0, 0, 1'b1);
                return;
            end
        end
        if (digits_taken >= count_held) return;

        group_value = group_value * 10 + d;
        digits_taken++;
        pos   = digits_taken;
        int_n = count_held - scale_held;
        last  = (pos == count_held);
        is_int = (pos <= int_n);
        w = group_value;
        if (is_int) begin
            closes = ((int_n - pos) % GROUP_DIGITS) == 0;
        end else begin
            tail = (pos - int_n) % GROUP_DIGITS;
            if (tail == 0) begin
                closes = 1'b1;
            end else if (last) begin
                // short fraction tail is left-aligned within its group
                closes = 1'b1;
                repeat (GROUP_DIGITS - tail) w = w * 10;
            end
        end
        if (!closes) return;

        group_value = 0;
        if (is_int && w == 0 && slot_next == 0) begin
            // leading zero integer group is dropped
            int_tally = int_n - pos;
            push_word(0, 1'b0, 0, last);
        end else if (slot_next < SLOT_LIMIT) begin
            push_word(w, 1'b1, slot_next, last);
            slot_next++;
        end else begin
            push_word(0, 1'b0, 0, last);
        end
    endfunction

    task report_mismatch(string msg);
        if (fail_count < 100) $display("mismatch at result %0d: %s", result_index, msg);
        fail_count++;
    endtask

    task check_result(t_result got);
        t_result want;
        if (pending_words.size() == 0) begin
            report_mismatch("result with nothing pending");
        end else begin
            want = pending_words.pop_front();
            if (got.word != want.word)
                report_mismatch($sformatf("word %0d, want %0d", got.word, want.word));
            if (got.word_valid != want.word_valid)
                report_mismatch($sformatf("word_valid %0b, want %0b",
                                          got.word_valid, want.word_valid));
            if (got.word_slot != want.word_slot)
                report_mismatch($sformatf("word_slot %0d, want %0d",
                                          got.word_slot, want.word_slot));
            if (got.int_digits != want.int_digits)
                report_mismatch($sformatf("int_digits %0d, want %0d",
                                          got.int_digits, want.int_digits));
            if (got.frac_digits != want.frac_digits)
                report_mismatch($sformatf("frac_digits %0d, want %0d",
                                          got.frac_digits, want.frac_digits));
            if (got.negative_out != want.negative_out)
                report_mismatch($sformatf("negative_out %0b, want %0b",
                                          got.negative_out, want.negative_out));
            if (got.number_done != want.number_done)
                report_mismatch($sformatf("number_done %0b, want %0b",
                                          got.number_done, want.number_done));
        end
        result_index++;
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned DIGIT_GOAL  = 650;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic [DIGIT_W-1:0] i_digit       = '0;
    logic [COUNT_W-1:0] i_digit_count = '0;
    logic [SCALE_W-1:0] i_scale_in    = '0;
    logic               i_negative_in = 1'b0;
    logic               i_first_digit = 1'b0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic [WORD_W-1:0]  o_word;
    logic               o_word_valid;
    logic [SLOT_W-1:0]  o_word_slot;
    logic [COUNT_W-1:0] o_int_digits;
    logic [SCALE_W-1:0] o_frac_digits;
    logic               o_negative_out;
    logic               o_number_done;

    digit_pack_scoreboard sb;
    bit          quiet_in     = 1'b0;
    int unsigned digits_used  = 0;
    int unsigned stall_hold   = 0;
    int unsigned idle_cycles  = 0;

    decimal_digits_to_word_packer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_digit        (i_digit),
        .i_digit_count  (i_digit_count),
        .i_scale_in     (i_scale_in),
        .i_negative_in  (i_negative_in),
        .i_first_digit  (i_first_digit),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_word         (o_word),
        .o_word_valid   (o_word_valid),
        .o_word_slot    (o_word_slot),
        .o_int_digits   (o_int_digits),
        .o_frac_digits  (o_frac_digits),
        .o_negative_out (o_negative_out),
        .o_number_done  (o_number_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_item make_item(logic [DIGIT_W-1:0] d, logic [COUNT_W-1:0] cnt,
                                        logic [SCALE_W-1:0] sc, logic neg, logic first);
        t_item it;
        it.digit       = d;
        it.digit_count = cnt;
        it.scale_in    = sc;
        it.negative_in = neg;
        it.first_digit = first;
        return it;
    endfunction

    function automatic int unsigned gap_cycles();
        int unsigned r;
        if (quiet_in) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DIGIT_W-1:0] pick_digit(int unsigned zero_pct);
        if ($urandom_range(99) < zero_pct) return '0;
        if ($urandom_range(19) == 0) return DIGIT_W'($urandom_range(10, 15));
        return DIGIT_W'($urandom_range(0, 9));
    endfunction

    task automatic send_word(t_item it);
        int unsigned gap;
        gap = gap_cycles();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_digit       <= it.digit;
        i_digit_count <= it.digit_count;
        i_scale_in    <= it.scale_in;
        i_negative_in <= it.negative_in;
        i_first_digit <= it.first_digit;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_digit(it);
    endtask

    // One number: first word carries count/scale/sign; sent may fall short of
    // or run past the count to abandon the number or add trailing words.
    task automatic send_number(int unsigned cnt, int unsigned sc, bit neg,
                               int unsigned sent, int unsigned zero_pct);
        int unsigned eff, k;
        eff = (cnt > 65) ? 65 : cnt;
        quiet_in = ($urandom_range(3) == 0);
        for (k = 0; k < sent; k++)
            send_word(make_item(pick_digit(zero_pct), COUNT_W'(cnt), SCALE_W'(sc),
                                neg, k == 0));
        digits_used += (cnt == 0) ? 1 : ((sent < eff) ? sent : eff);
    endtask

    // receiver stall: short and long stall bursts, occasional long clear stretches
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold--;
        end else if ($urandom_range(99) < 35) begin
            i_stall <= 1'b1;
            stall_hold = ($urandom_range(9) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
            stall_hold = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 20);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.word         = o_word;
            got.word_valid   = o_word_valid;
            got.word_slot    = o_word_slot;
            got.int_digits   = o_int_digits;
            got.frac_digits  = o_frac_digits;
            got.negative_out = o_negative_out;
            got.number_done  = o_number_done;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned r, cnt, eff, sc, sent, zero_pct;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // words before any first word are dropped
        send_word(make_item(4'd5, 7'd0, 5'd0, 1'b0, 1'b0));
        send_word(make_item(4'd15, 7'd127, 5'd31, 1'b1, 1'b0));
        // zero decimal: digit ignored, scale clipped to zero
        send_word(make_item(4'd15, 7'd0, 5'd31, 1'b1, 1'b1));
        send_word(make_item(4'd9, 7'd1, 5'd0, 1'b0, 1'b1));
        // scale past count: all fraction, digit above nine clamps
        send_word(make_item(4'd15, 7'd3, 5'd30, 1'b1, 1'b1));
        send_word(make_item(4'd0, 7'd3, 5'd30, 1'b1, 1'b0));
        send_word(make_item(4'd7, 7'd3, 5'd30, 1'b1, 1'b0));
        // all-zero integer part: both integer groups dropped
        send_number(10, 0, 1'b0, 10, 100);
        // trailing words past the count
        send_number(2, 1, 1'b0, 4, 0);
        // number abandoned by an early first word
        send_number(5, 2, 1'b1, 2, 0);
        send_number(2, 1, 1'b1, 2, 0);

        // count saturates at the limit
        send_number(127, 31, 1'b1, 65, 0);
        send_number(65, 0, 1'b0, 65, 60);

        while (digits_used < DIGIT_GOAL) begin
            r = $urandom_range(99);
            cnt = $urandom_range(99);
            if (cnt < 75) cnt = $urandom_range(1, 20);
            else if (cnt < 95) cnt = $urandom_range(21, 65);
            else cnt = $urandom_range(66, 127);
            eff = (cnt > 65) ? 65 : cnt;
            sc = ($urandom_range(9) == 0) ? $urandom_range(0, 31)
                                          : $urandom_range(0, (eff < 30) ? eff : 30);
            sent = eff;
            zero_pct = 10;
            if (r < 70) begin
                zero_pct = $urandom_range(0, 20);
            end else if (r < 80) begin
                zero_pct = 85;
            end else if (r < 87) begin
                if (eff > 1) sent = $urandom_range(1, eff - 1);
            end else if (r < 94) begin
                sent = eff + $urandom_range(1, 4);
            end else begin
                cnt = 0;
                sent = 1;
            end
            send_number(cnt, sc, 1'($urandom_range(1)), sent, zero_pct);
        end
        i_valid <= 1'b0;

        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

/* files.f */
design/ddwp_pkg.sv
design/ddwp_in_reg.sv
design/ddwp_core.sv
design/ddwp_out_reg.sv
design/decimal_digits_to_word_packer.sv
design/ddwp_checker.sv
tb/sv/testbench.sv
